/* rtl/cubic_table_interpolator_macros.svh */
// Assertion macros shared by the cubic table interpolator RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef CUBIC_TABLE_INTERPOLATOR_MACROS_SVH
`define CUBIC_TABLE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication; the consequent may open with a fixed delay.
`define CTI_ASSERT_IMPL(LBL, CLK, RST, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |-> (CONS)) \
    else $error("cubic_table_interpolator: assertion failed");

// Next-cycle implication.
`define CTI_ASSERT_NEXT(LBL, CLK, RST, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |=> (CONS)) \
    else $error("cubic_table_interpolator: assertion failed");

`endif

/* rtl/cti_pkg.sv */
// Shared constants, types and the saturation helper for the cubic table interpolator.
// No dependencies.
package cti_pkg;

  localparam int TABLE_ROWS    = 1024;
  localparam int FRACTION_BITS = 16;
  localparam int ROW_WORDS     = 5;
  localparam int ROW_BITS      = $clog2(TABLE_ROWS);
  localparam int WORD_W        = 32;
  localparam int SLOT_W        = 3;
  localparam int ROW_INDEX_W   = 10;
  localparam int POINTS_W      = 11;
  localparam int CFG_INDEX_W   = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } cti_op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LOWER_BOUND = 2'd0,
    CFG_INV_SPACING = 2'd1,
    CFG_POINTS      = 2'd2
  } cti_cfg_t;

  localparam logic [SLOT_W-1:0] SLOT_MID = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_C0  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_C1  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_C2  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_C3  = 3'd4;

  // One table row: midpoint and c0..c3, indexed by the slot codes.
  typedef logic [ROW_WORDS-1:0][WORD_W-1:0] cti_row_t;

  typedef struct packed {
    logic                write;
    logic                read;
    logic [ROW_BITS-1:0] addr;
    logic [SLOT_W-1:0]   slot;
    logic [WORD_W-1:0]   value;
  } cti_tbl_req_t;

  typedef struct packed {
    logic valid;
    logic oor;
  } cti_ctl_t;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/cti_row_table.sv */
// Coefficient row store: five word banks sharing one address, registered read.
// Depends on cti_pkg.
module cti_row_table (
  input  logic                 clk,
  input  cti_pkg::cti_tbl_req_t req,
  output cti_pkg::cti_row_t    rd_data
);

  for (genvar s = 0; s < cti_pkg::ROW_WORDS; s++) begin : g_bank
    logic [cti_pkg::WORD_W-1:0] mem [cti_pkg::TABLE_ROWS];
    logic [cti_pkg::WORD_W-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (req.write && req.slot == cti_pkg::SLOT_W'(s)) begin
        mem[req.addr] <= req.value;
      end
      if (req.read) begin
        rd_q <= mem[req.addr];
      end
    end

    assign rd_data[s] = rd_q;
  end

endmodule

/* rtl/cti_poly_eval.sv */
// Cubic evaluation pipeline: offset, products, saturated sums, clamped square, quadratic product, result register.
// Depends on cti_pkg.
module cti_poly_eval (
  input  logic                         clk,
  input  logic                         rst,
  input  cti_pkg::cti_ctl_t            ctl,
  input  logic signed [31:0]           x,
  input  cti_pkg::cti_row_t            row,
  output logic                         done,
  output logic signed [31:0]           interpolated,
  output logic                         out_of_range
);

  localparam int F = cti_pkg::FRACTION_BITS;

  logic              v4, v5, v6, v7, v8;
  logic              oor4, oor5, oor6, oor7, oor8;
  logic signed [32:0] d4;
  logic signed [31:0] c0_4, c1_4, c2_4, c3_4, c0_5, c2_5;
  logic signed [64:0] p1_5, p3_5;
  logic        [31:0] dmag5;
  logic signed [31:0] lin6, inner6, lin7, inner7, lin8;
  logic        [63:0] dsq6, dshift6;
  logic        [31:0] dd7;
  logic signed [64:0] qp8;
  logic signed [31:0] quad8, sum8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      v8   <= 1'b0;
      done <= 1'b0;
    end else begin
      v4   <= ctl.valid;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      v8   <= v7;
      done <= v8;
    end
  end

  assign dshift6 = dsq6 >> F;
  assign quad8   = cti_pkg::sat32(66'(qp8 >>> F));
  assign sum8    = cti_pkg::sat32(66'(lin8) + 66'(quad8));

  always_ff @(posedge clk) begin
    // offset from the row midpoint
    oor4 <= ctl.oor;
    d4   <= $signed({x[31], x}) -
            $signed({row[cti_pkg::SLOT_MID][31], row[cti_pkg::SLOT_MID]});
    c0_4 <= row[cti_pkg::SLOT_C0];
    c1_4 <= row[cti_pkg::SLOT_C1];
    c2_4 <= row[cti_pkg::SLOT_C2];
    c3_4 <= row[cti_pkg::SLOT_C3];

    // products with c1 and c3, and offset magnitude
    oor5  <= oor4;
    p1_5  <= 65'(d4) * 65'(c1_4);
    p3_5  <= 65'(d4) * 65'(c3_4);
    dmag5 <= d4[32] ? 32'(-d4) : 32'(d4);
    c0_5  <= c0_4;
    c2_5  <= c2_4;

    // saturated partial sums, squared offset
    oor6   <= oor5;
    lin6   <= cti_pkg::sat32(66'(c0_5) + 66'(cti_pkg::sat32(66'(p1_5 >>> F))));
    inner6 <= cti_pkg::sat32(66'(c2_5) + 66'(cti_pkg::sat32(66'(p3_5 >>> F))));
    dsq6   <= 64'(dmag5) * 64'(dmag5);

    // clamp the scaled square
    oor7   <= oor6;
    dd7    <= (dshift6 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dshift6[31:0];
    lin7   <= lin6;
    inner7 <= inner6;

    // quadratic term product
    oor8 <= oor7;
    qp8  <= 65'($signed({1'b0, dd7})) * 65'(inner7);
    lin8 <= lin7;

    // result register
    out_of_range <= oor8;
    interpolated <= oor8 ? 32'sd0 : sum8;
  end

endmodule

/* rtl/cubic_table_interpolator.sv */
// Top level of the piecewise cubic table interpolator.
// Depends on cti_pkg, cti_row_table, cti_poly_eval and cubic_table_interpolator_macros.svh.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  config    | cfg_write            | cfg_index, cfg_data
//  command   | start, busy          | opcode, row_index, word_slot, word_value,
//            |                      | query_point
//  result    | done (one-cycle)     | interpolated, out_of_range
//
// One command is taken every clock; busy stays low. An evaluate reaches its result
// through nine register stages: offset from the lower bound, row-index multiply,
// row decode and table read, midpoint offset, four multiply/saturate stages, then the
// result register. Table writes travel the same pipe and land at the table-read stage,
// so every evaluate sees exactly the writes taken before it.
// rst is synchronous: config registers return to their defaults, stage valid bits clear;
// the table holds whatever was written. The receiver cannot stall, so nothing ever holds.
`include "cubic_table_interpolator_macros.svh"

module cubic_table_interpolator (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [cti_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [31:0]                             cfg_data,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    opcode,
  input  logic [cti_pkg::ROW_INDEX_W-1:0]         row_index,
  input  logic [cti_pkg::SLOT_W-1:0]              word_slot,
  input  logic signed [31:0]                      word_value,
  input  logic signed [31:0]                      query_point,
  output logic                                    done,
  output logic signed [31:0]                      interpolated,
  output logic                                    out_of_range
);

  localparam int RESULT_LATENCY = 9;

  // Configuration registers
  logic signed [31:0]                lower_bound;
  logic        [31:0]                inverse_spacing;
  logic [cti_pkg::POINTS_W-1:0]      points_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound     <= 32'sd0;
      inverse_spacing <= 32'd65536;
      points_in_use   <= cti_pkg::POINTS_W'(1024);
    end else if (cfg_write) begin
      unique case (cfg_index)
        cti_pkg::CFG_LOWER_BOUND: lower_bound     <= cfg_data;
        cti_pkg::CFG_INV_SPACING: inverse_spacing <= cfg_data;
        cti_pkg::CFG_POINTS:      points_in_use   <= cfg_data[cti_pkg::POINTS_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // The pipe never stalls, so a command transfers whenever start is high.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: exact 33-bit offset from the lower bound, split into sign and magnitude.
  logic [32:0] diff0, mag0;
  assign diff0 = $signed({query_point[31], query_point}) -
                 $signed({lower_bound[31], lower_bound});
  assign mag0  = diff0[32] ? (~diff0 + 33'd1) : diff0;

  logic                               v1, v2;
  cti_pkg::cti_op_t                   op1, op2;
  logic [cti_pkg::ROW_INDEX_W-1:0]    row1, row2;
  logic [cti_pkg::SLOT_W-1:0]         slot1, slot2;
  logic [31:0]                        word1, word2;
  logic signed [31:0]                 x1, x2, x3;
  logic                               neg1, neg2;
  logic [31:0]                        mag1;
  logic [63:0]                        prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    op1   <= cti_pkg::cti_op_t'(opcode);
    row1  <= row_index;
    slot1 <= word_slot;
    word1 <= word_value;
    x1    <= query_point;
    neg1  <= diff0[32];
    // magnitude never exceeds 2^32 - 1, so the top bit is always clear
    mag1  <= mag0[31:0];

    // Stage 2: scale the offset by the inverse spacing.
    op2   <= op1;
    row2  <= row1;
    slot2 <= slot1;
    word2 <= word1;
    x2    <= x1;
    neg2  <= neg1;
    prod2 <= 64'(mag1) * 64'(inverse_spacing);
  end

  // Stage 3: row decode, range check and the table access.
  // A negative offset that truncates to zero still lands on row 0.
  logic [63:0]           q2;
  logic                  oor2;
  cti_pkg::cti_tbl_req_t tbl_req;
  cti_pkg::cti_row_t     row_q;
  cti_pkg::cti_ctl_t     ctl3;

  assign q2   = prod2 >> (2 * cti_pkg::FRACTION_BITS);
  assign oor2 = (neg2 && q2 != 64'd0) ||
                (q2 >= 64'(points_in_use)) ||
                (q2 >= 64'(cti_pkg::TABLE_ROWS));

  always_comb begin
    tbl_req.write = v2 && (op2 == cti_pkg::OP_WRITE) &&
                    (32'(row2) < cti_pkg::TABLE_ROWS) &&
                    (32'(slot2) < cti_pkg::ROW_WORDS);
    tbl_req.read  = v2 && (op2 == cti_pkg::OP_EVAL);
    tbl_req.addr  = (op2 == cti_pkg::OP_EVAL) ? q2[cti_pkg::ROW_BITS-1:0]
                                              : cti_pkg::ROW_BITS'(row2);
    tbl_req.slot  = slot2;
    tbl_req.value = word2;
  end

  cti_row_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (row_q)
  );

  always_ff @(posedge clk) begin
    ctl3.oor <= oor2;
    x3       <= x2;
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else begin
      ctl3.valid <= tbl_req.read;
    end
  end

  // Stages 4 to 9: cubic evaluation and the result register.
  cti_poly_eval u_poly (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl3),
    .x            (x3),
    .row          (row_q),
    .done         (done),
    .interpolated (interpolated),
    .out_of_range (out_of_range)
  );

  // Every evaluate transfer yields exactly one result,
  // and no result appears without one.
  `CTI_ASSERT_IMPL(a_eval_gives_result, clk, rst, accept && opcode == cti_pkg::OP_EVAL, ##RESULT_LATENCY done)
  `CTI_ASSERT_IMPL(a_result_has_eval, clk, rst, done, $past(accept && opcode == cti_pkg::OP_EVAL, RESULT_LATENCY))

endmodule

/* tb/cubic_table_interpolator_tb.sv */
// Self-checking testbench for cubic_table_interpolator: loads table rows, evaluates queries
// and checks every result against an in-bench predictor of the row lookup and cubic math.
// Depends on cti_pkg and the cubic_table_interpolator RTL.
module cubic_table_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cti_pkg::*;

  // Table writes produce no result, so before touching the config registers the bench
  // waits for every result and then lets the pipe empty of writes.
  localparam int PIPE_LATENCY = 9;
  localparam int MAX_GAP      = 13;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index, must be ignored
  localparam longint INT32_TOP    = 64'sd2147483647;
  localparam longint INT32_BOTTOM = -64'sd2147483648;

  typedef struct {
    cti_op_t                  op;
    logic [ROW_INDEX_W-1:0]   row;
    logic [SLOT_W-1:0]        slot;
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] query;
    int                       gap;    // idle cycles after this transfer
    bit                       drain;  // hold off until every result is back
  } command_t;

  typedef struct {
    logic signed [WORD_W-1:0] value;
    logic                     oor;
  } cubic_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [31:0]                cfg_data = '0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       opcode = OP_WRITE;
  logic [ROW_INDEX_W-1:0]     row_index = '0;
  logic [SLOT_W-1:0]          word_slot = '0;
  logic signed [31:0]         word_value = '0;
  logic signed [31:0]         query_point = '0;
  logic                       done;
  logic signed [31:0]         interpolated;
  logic                       out_of_range;

  cubic_table_interpolator DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .row_index    (row_index),
    .word_slot    (word_slot),
    .word_value   (word_value),
    .query_point  (query_point),
    .done         (done),
    .interpolated (interpolated),
    .out_of_range (out_of_range)
  );

  // Predictor copy of the configuration and the coefficient table.
  logic signed [WORD_W-1:0]   lower_bound_q   = '0;
  logic [WORD_W-1:0]          inv_spacing_q   = 32'd65536;
  logic [POINTS_W-1:0]        points_q        = 11'd1024;
  logic signed [WORD_W-1:0]   row_words_q [TABLE_ROWS][ROW_WORDS];

  // Generator bookkeeping: which words will have been written once the backlog drains.
  bit [ROW_WORDS-1:0]         loaded_words [TABLE_ROWS];

  command_t                   command_backlog[$];
  cubic_result_t              queued_interpolations[$];

  logic                       xfer_seen = 1'b0;
  int                         gap_left = 0;
  int                         gap_max = MAX_GAP;
  bit                         drain_next = 1'b0;
  int                         items_queued = 0;

  int                         mismatch_count = 0;
  int                         eval_count = 0;
  int                         oor_count = 0;
  int                         sat_count = 0;
  int                         write_count = 0;
  int                         settings_count = 0;

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(input longint v);
    if (v > INT32_TOP) return INT32_TOP;
    if (v < INT32_BOTTOM) return INT32_BOTTOM;
    return v;
  endfunction

  // Row = trunc((x - lower_bound) * inverse_spacing), toward zero. A negative offset
  // that truncates to zero still lands on row 0.
  function automatic void find_row(input logic signed [WORD_W-1:0] x,
                                   output int unsigned row, output bit oor);
    longint          diff;
    longint unsigned mag, prod, q, lim;
    diff = longint'(x) - longint'(lower_bound_q);
    mag  = (diff < 0) ? -diff : diff;
    prod = mag * {32'h0, inv_spacing_q};
    q    = prod >> (2 * FRACTION_BITS);
    lim  = (points_q < TABLE_ROWS) ? 64'(points_q) : 64'(TABLE_ROWS);
    oor  = (diff < 0 && q != 0) || q >= lim;
    row  = oor ? 0 : int'(q);
  endfunction

  function automatic cubic_result_t interpolate_at(input logic signed [WORD_W-1:0] x);
    cubic_result_t   r;
    int unsigned     row;
    bit              oor;
    longint          d, c0, c1, c2, c3, lin, inner, dd, quad;
    longint unsigned dmag, sq;
    find_row(x, row, oor);
    if (oor) begin
      r.value = '0;
      r.oor   = 1'b1;
      return r;
    end
    d  = longint'(x) - longint'(row_words_q[row][SLOT_MID]);
    c0 = row_words_q[row][SLOT_C0];
    c1 = row_words_q[row][SLOT_C1];
    c2 = row_words_q[row][SLOT_C2];
    c3 = row_words_q[row][SLOT_C3];
    // Floor each product, clamp it, then clamp each sum.
    lin   = clamp32(c0 + clamp32((d * c1) >>> FRACTION_BITS));
    inner = clamp32(c2 + clamp32((d * c3) >>> FRACTION_BITS));
    dmag  = (d < 0) ? -d : d;
    sq    = (dmag * dmag) >> FRACTION_BITS;
    dd    = (sq > 64'd2147483647) ? INT32_TOP : longint'(sq);
    quad  = clamp32((dd * inner) >>> FRACTION_BITS);
    r.value = 32'(clamp32(lin + quad));
    r.oor   = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return int'($urandom_range(0, 2)) - 1;
      3, 4:    return $urandom;
      default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  // Pick a query that should land inside the given row under the current settings.
  function automatic logic signed [WORD_W-1:0] aim_at_row(input longint unsigned row);
    longint unsigned span;
    longint          x;
    if (inv_spacing_q == 0) return $urandom;
    span = ((row << (2 * FRACTION_BITS)) + $urandom) / inv_spacing_q;
    x    = longint'(lower_bound_q) + longint'(span);
    if (x > INT32_TOP) return $urandom;
    return x[31:0];
  endfunction

  task automatic enqueue(input command_t c, input bit counted);
    c.gap   = $urandom_range(0, gap_max);
    c.drain = drain_next;
    drain_next = 1'b0;
    command_backlog.push_back(c);
    if (counted) items_queued++;
  endtask

  task automatic push_write(input int unsigned row, input logic [SLOT_W-1:0] slot,
                            input logic signed [WORD_W-1:0] value);
    command_t c;
    c.op    = OP_WRITE;
    c.row   = row[ROW_INDEX_W-1:0];
    c.slot  = slot;
    c.value = value;
    c.query = $urandom;
    // Slots past c3 are dropped by the block and do not count as real items.
    if (slot < ROW_WORDS) loaded_words[row][slot] = 1'b1;
    enqueue(c, slot < ROW_WORDS);
  endtask

  // Load a row; keep the midpoint near the expected queries most of the time so the
  // cubic does not simply saturate.
  task automatic fill_row(input int unsigned row, input logic signed [WORD_W-1:0] near_x,
                          input bit only_missing);
    logic signed [WORD_W-1:0] mid;
    for (int s = 0; s < ROW_WORDS; s++) begin
      if (!only_missing || !loaded_words[row][s]) begin
        if (s == SLOT_MID) begin
          mid = ($urandom_range(0, 9) < 7) ?
                int'(near_x) + int'($urandom_range(0, 1 << 18)) - (1 << 17) : rand_word();
          push_write(row, SLOT_MID, mid);
        end else begin
          push_write(row, s[SLOT_W-1:0], rand_word());
        end
      end
    end
  endtask

  // Never let an evaluate read a word that was not written: top up its row first.
  task automatic push_eval(input logic signed [WORD_W-1:0] x);
    command_t    c;
    int unsigned row;
    bit          oor;
    find_row(x, row, oor);
    if (!oor && loaded_words[row] != '1) fill_row(row, x, 1'b1);
    c.op    = OP_EVAL;
    c.row   = ROW_INDEX_W'($urandom);
    c.slot  = SLOT_W'($urandom);
    c.value = $urandom;
    c.query = x;
    enqueue(c, 1'b1);
  endtask

  task automatic directed_checks();
    // Row 0 with moderate coefficients, evaluated inside, just below and past the bound.
    push_write(0, SLOT_MID, 32'sd0);
    push_write(0, SLOT_C0, 32'sd65536);
    push_write(0, SLOT_C1, 32'sd131072);
    push_write(0, SLOT_C2, -32'sd65536);
    push_write(0, SLOT_C3, 32'sd32768);
    push_eval(32'sh0000_8000);
    push_eval(-32'sd1);                   // negative offset that truncates to row 0
    push_eval(-32'sd65536);               // row -1
    push_eval(32'sh8000_0000);
    push_eval(32'sh7FFF_FFFF);
    // Last row with extreme words, so both offset products, the linear sum and the scaled square saturate.
    push_write(TABLE_ROWS - 1, SLOT_MID, 32'sh8000_0000);
    push_write(TABLE_ROWS - 1, SLOT_C0, 32'sh7FFF_FFFF);
    push_write(TABLE_ROWS - 1, SLOT_C1, 32'sh7FFF_FFFF);
    push_write(TABLE_ROWS - 1, SLOT_C2, 32'sh8000_0000);
    push_write(TABLE_ROWS - 1, SLOT_C3, 32'sh7FFF_FFFF);
    push_eval(32'sh03FF_FFFF);
    push_eval(32'sh0400_0000);            // first row past the table
    // Bad slots must leave row 0 untouched.
    push_write(0, 3'd7, 32'sh8000_0000);
    push_write(0, 3'd5, 32'sh7FFF_FFFF);
    drain_next = 1'b1;
    push_eval(32'sd0);
  endtask

  task automatic run_random(input int count);
    int                       goal, sel;
    int unsigned              lim, r;
    longint                   below;
    goal = items_queued + count;
    while (items_queued < goal) begin
      // Toggle between idle-heavy stretches and back-to-back bursts.
      if ($urandom_range(0, 39) == 0) gap_max = (gap_max != 0) ? 0 : MAX_GAP;
      if ($urandom_range(0, 99) == 0) drain_next = 1'b1;
      lim = (points_q < TABLE_ROWS) ? points_q : TABLE_ROWS;
      sel = $urandom_range(0, 99);
      if (sel < 50 && lim > 0) begin
        push_eval(aim_at_row($urandom_range(0, lim - 1)));
      end else if (sel < 58) begin
        // Rows around the upper end of the range in use.
        push_eval(aim_at_row(longint'(lim) + $urandom_range(0, 3) - ((lim > 0) ? 1 : 0)));
      end else if (sel < 63) begin
        below = longint'(lower_bound_q) - longint'($urandom_range(1, 1 << 17));
        push_eval((below < INT32_BOTTOM) ? $urandom : below[31:0]);
      end else if (sel < 70) begin
        push_eval($urandom);
      end else if (sel < 83) begin
        r = (lim > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, lim - 1)
                                                   : $urandom_range(0, TABLE_ROWS - 1);
        fill_row(r, aim_at_row(r), 1'b0);
      end else if (sel < 93) begin
        push_write($urandom_range(0, TABLE_ROWS - 1),
                   SLOT_W'($urandom_range(0, ROW_WORDS - 1)), rand_word());
      end else begin
        push_write($urandom_range(0, TABLE_ROWS - 1),
                   SLOT_W'($urandom_range(ROW_WORDS, 7)), $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------

  // Wait for every transfer and every result, then let the pipe empty of writes.
  task automatic wait_idle();
    while (command_backlog.size() != 0 || queued_interpolations.size() != 0)
      @(negedge clk);
    repeat (PIPE_LATENCY + 3) @(negedge clk);
  endtask

  // Called on a falling edge; leaves cfg_write high for the caller to drop.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_LOWER_BOUND: lower_bound_q = data;
      CFG_INV_SPACING: inv_spacing_q = data;
      CFG_POINTS:      points_q      = data[POINTS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] bound, input logic [31:0] inv,
                                input logic [POINTS_W-1:0] pts);
    logic [31:0] pts_word;
    wait_idle();
    pts_word = $urandom;
    pts_word[POINTS_W-1:0] = pts;
    write_register(CFG_LOWER_BOUND, bound);
    write_register(CFG_INV_SPACING, inv);
    write_register(CFG_POINTS, pts_word);
    write_register(CFG_SPARE, $urandom);
    cfg_write <= 1'b0;
    settings_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the head of the backlog on the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : drive_commands
    bit present;
    present = 1'b0;
    if (!rst) begin
      if (start && !xfer_seen) begin
        present = 1'b1;                   // hold: not taken yet
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (command_backlog.size() != 0 &&
                   !(command_backlog[0].drain && queued_interpolations.size() != 0)) begin
        opcode      <= command_backlog[0].op;
        row_index   <= command_backlog[0].row;
        word_slot   <= command_backlog[0].slot;
        word_value  <= command_backlog[0].value;
        query_point <= command_backlog[0].query;
        gap_left    = command_backlog[0].gap;
        present     = 1'b1;
      end
    end
    start <= present;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each transfer, check each done strobe, both on the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : track_transfers
    cubic_result_t want;
    if (rst) begin
      xfer_seen <= 1'b0;
    end else begin
      // Check the result first: it always belongs to an earlier transfer.
      if (done) begin
        if (queued_interpolations.size() == 0) begin
          $display("%0t: result with nothing pending: interpolated %h out_of_range %b",
                   $time, interpolated, out_of_range);
          mismatch_count++;
        end else begin
          want = queued_interpolations.pop_front();
          if (interpolated !== want.value) begin
            $display("%0t: interpolated mismatch: expected %h actual %h",
                     $time, want.value, interpolated);
            mismatch_count++;
          end
          if (out_of_range !== want.oor) begin
            $display("%0t: out_of_range mismatch: expected %b actual %b",
                     $time, want.oor, out_of_range);
            mismatch_count++;
          end
        end
      end
      xfer_seen <= start && !busy;
      if (start && !busy) begin
        if (opcode == OP_WRITE) begin
          if (word_slot < ROW_WORDS) row_words_q[row_index][word_slot] = word_value;
          write_count++;
        end else begin
          want = interpolate_at(query_point);
          queued_interpolations.push_back(want);
          eval_count++;
          if (want.oor) oor_count++;
          else if (want.value == 32'sh7FFF_FFFF || want.value == 32'sh8000_0000) sat_count++;
        end
        void'(command_backlog.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin : run_sequence
    int spins;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: bound 0, spacing 1.0, full table.
    directed_checks();
    run_random(300);

    // Zero inverse spacing: every query maps to row 0, a single row in use.
    apply_settings(32'h8000_0000, 32'h0, 11'd1);
    run_random(120);

    // Zero points in use with the largest bound and spacing: everything out of range.
    apply_settings(32'h7FFF_FFFF, 32'hFFFF_FFFF, 11'd0);
    run_random(80);

    // Quarter spacing over 64 rows starting at -8.0.
    apply_settings(32'hFFF8_0000, 32'h0004_0000, 11'd64);
    run_random(250);

    // Points above the table size: rows past the table stay out of range.
    apply_settings(32'hFE00_0000, 32'h0001_0000, 11'd2047);
    run_random(200);

    apply_settings(int'($urandom_range(0, 1 << 25)) - (1 << 24),
                   $urandom_range(1 << 12, 1 << 20),
                   POINTS_W'($urandom_range(1, TABLE_ROWS)));
    run_random(200);

    apply_settings($urandom, $urandom, POINTS_W'($urandom));
    run_random(150);

    // Drain: all transfers taken, then a bounded wait for the remaining results.
    while (command_backlog.size() != 0) @(negedge clk);
    spins = 0;
    while (queued_interpolations.size() != 0 && spins < 1000) begin
      spins++;
      @(negedge clk);
    end
    repeat (PIPE_LATENCY + 3) @(negedge clk);
    if (queued_interpolations.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, queued_interpolations.size());
      mismatch_count += queued_interpolations.size();
    end

    $display("Ran %0d evaluations (%0d out of range, %0d saturated) and %0d table writes",
             eval_count, oor_count, sat_count, write_count);
    $display("across %0d register settings plus reset values; %0d mismatches",
             settings_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
